// File: hdl/number_text_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the number text parser.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TEXT_PARSER_ASSERT_SVH
`define NUMBER_TEXT_PARSER_ASSERT_SVH

// same-cycle implication
`define NTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ntp_pkg.sv
// ----------------------------------------------------------------------------
// Number text parser package
// Parse modes and character codes shared by the parser files.
// ----------------------------------------------------------------------------
package ntp_pkg;

  typedef enum logic [1:0] {
    MODE_DEC  = 2'd0,
    MODE_HEX  = 2'd1,
    MODE_DONE = 2'd2
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_K_LO  = 8'h6b;
  localparam logic [7:0] CH_K_UP  = 8'h4b;
  localparam logic [7:0] CH_M_LO  = 8'h6d;
  localparam logic [7:0] CH_M_UP  = 8'h4d;

  localparam logic [3:0] DIGIT_LIMIT = 4'd11;
  localparam logic [3:0] HEX_START   = 4'd2;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } nibble_t;

  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t r;
    r.ok  = 1'b1;
    r.nib = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r.nib = c[3:0];
    end else if ((c >= CH_A_LO && c <= CH_F_LO) || (c >= CH_A_UP && c <= CH_F_UP)) begin
      r.nib = c[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hdl/ntp_if.sv
// ----------------------------------------------------------------------------
// Parser channels
// Character request channel and result request channel.
// ----------------------------------------------------------------------------
interface ntp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ntp_res_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] value;

  modport source (output valid, output valid_res, output value, input ready);
  modport sink   (input valid, input valid_res, input value, output ready);
endinterface

// File: hdl/number_text_parser.sv
// ----------------------------------------------------------------------------
// Number text parser
// Parses NUL-terminated ASCII hex or decimal text into a 32-bit value.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle, back to back, unless a NUL waits, set
// by the single shift-add on the accumulator between the character register and
// the parse state. A character is held in the input register until it advances;
// on the NUL the result goes from there into the result register to be taken.
// Non-NUL characters keep flowing while a result waits; a NUL waits only if the
// result register is still occupied and not being taken.
// Strings with a 0x/0X prefix take up to 8 hex digits, others up to 10 decimal
// digits with an optional k/K/m/M suffix; invalid strings report value 0.
module number_text_parser
  import ntp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ntp_char_if.sink     in_ch,
  ntp_res_if.source    out_ch
);

`include "number_text_parser_assert.svh"

  logic        in_v_r;
  logic [7:0]  char_r;
  logic        adv;
  logic        is_nul;

  mode_t       mode_r,  mode_nxt;
  logic [3:0]  pos_r,   pos_nxt;
  logic [31:0] acc_r,   acc_nxt;
  logic        ok_r,    ok_nxt;
  logic        fz_r,    fz_nxt;

  logic        out_v_r;
  logic        res_ok_r, res_ok_nxt;
  logic [31:0] res_val_r, res_val_nxt;

  logic [3:0]  pos_inc;
  logic [31:0] dec_acc;
  logic [31:0] hex_acc;
  logic        is_dig;
  nibble_t     hn;

  assign is_nul       = (char_r == CH_NUL);
  assign adv          = in_v_r && (!is_nul || !out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || adv;

  assign out_ch.valid     = out_v_r;
  assign out_ch.valid_res = res_ok_r;
  assign out_ch.value     = res_val_r;

  assign pos_inc = pos_r + 4'd1;
  assign is_dig  = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign dec_acc = (acc_r << 3) + (acc_r << 1) + {28'd0, char_r[3:0]};
  assign hn      = hex_nibble(char_r);
  assign hex_acc = (acc_r << 4) + {28'd0, hn.nib};

  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    ok_nxt      = ok_r;
    fz_nxt      = fz_r;
    res_ok_nxt  = res_ok_r;
    res_val_nxt = res_val_r;
    if (is_nul) begin
      unique case (mode_r)
        MODE_DEC: res_ok_nxt = 1'b1;
        MODE_HEX: res_ok_nxt = (pos_r > HEX_START);
        default:  res_ok_nxt = ok_r;
      endcase
      res_val_nxt = res_ok_nxt ? acc_r : 32'd0;
      mode_nxt    = MODE_DEC;
      pos_nxt     = 4'd0;
      acc_nxt     = 32'd0;
      ok_nxt      = 1'b0;
      fz_nxt      = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_DEC: begin
          priority if (pos_r == 4'd1 && fz_r && (char_r == CH_X_LO || char_r == CH_X_UP)) begin
            mode_nxt = MODE_HEX;
            pos_nxt  = HEX_START;
            acc_nxt  = 32'd0;
          end else if ((char_r == CH_K_LO || char_r == CH_K_UP) && pos_r != 4'd0) begin
            acc_nxt  = acc_r << 10;
            mode_nxt = MODE_DONE;
            ok_nxt   = 1'b1;
          end else if ((char_r == CH_M_LO || char_r == CH_M_UP) && pos_r != 4'd0) begin
            acc_nxt  = acc_r << 20;
            mode_nxt = MODE_DONE;
            ok_nxt   = 1'b1;
          end else if (is_dig) begin
            acc_nxt = dec_acc;
            pos_nxt = pos_inc;
            if (pos_r == 4'd0) begin
              fz_nxt = (char_r == CH_ZERO);
            end
            if (pos_inc >= DIGIT_LIMIT) begin
              mode_nxt = MODE_DONE;
              ok_nxt   = 1'b0;
              acc_nxt  = 32'd0;
            end
          end else begin
            mode_nxt = MODE_DONE;
            ok_nxt   = 1'b0;
            acc_nxt  = 32'd0;
          end
        end
        MODE_HEX: begin
          if (hn.ok) begin
            acc_nxt = hex_acc;
            pos_nxt = pos_inc;
            if (pos_inc >= DIGIT_LIMIT) begin
              mode_nxt = MODE_DONE;
              ok_nxt   = 1'b0;
              acc_nxt  = 32'd0;
            end
          end else begin
            mode_nxt = MODE_DONE;
            ok_nxt   = 1'b0;
            acc_nxt  = 32'd0;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      char_r <= in_ch.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DEC;
      pos_r  <= 4'd0;
      acc_r  <= 32'd0;
      ok_r   <= 1'b0;
      fz_r   <= 1'b0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      ok_r   <= ok_nxt;
      fz_r   <= fz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && is_nul) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_nul) begin
      res_ok_r  <= res_ok_nxt;
      res_val_r <= res_val_nxt;
    end
  end

  `NTP_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_v_r && !res_ok_r, res_val_r == 32'd0,
    "invalid result carries a non-zero value")
  `NTP_ASSERT_NEXT(a_nul_gives_result, clk, rst_n, adv && is_nul, out_v_r,
    "NUL request advanced without a result")
  `NTP_ASSERT_NOW(a_hex_position, clk, rst_n, mode_r == MODE_HEX,
    pos_r >= HEX_START && pos_r < DIGIT_LIMIT, "hex mode with impossible position")
  `NTP_ASSERT_NOW(a_position_bound, clk, rst_n, 1'b1, pos_r <= DIGIT_LIMIT,
    "position past digit limit")

endmodule

// File: tb/ntp_checker.sv
// ----------------------------------------------------------------------------
// Number text parser checker
// Watches the character and result channels, keeps its own copy of the parse
// state, predicts the verdict and value for every NUL-terminated string and
// compares each result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ntp_checker
  import ntp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ntp_char_if         in_mon,
  ntp_res_if          out_mon,
  output int unsigned fail_count,
  output int unsigned results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
  } parse_res_t;

  parse_res_t  expected_q[$];
  mode_t       mode;
  logic [3:0]  digits;
  logic [31:0] acc;
  logic        verdict;
  logic        lead_zero;

  function automatic void clear_parser();
    mode      = MODE_DEC;
    digits    = '0;
    acc       = '0;
    verdict   = 1'b0;
    lead_zero = 1'b0;
  endfunction

  function automatic void settle(input logic ok);
    mode    = MODE_DONE;
    verdict = ok;
    if (!ok) begin
      acc = '0;
    end
  endfunction

  function automatic void advance_parser(input logic [7:0] c);
    parse_res_t res;
    logic       ok;
    logic       is_hex;
    logic [3:0] nib;
    is_hex = 1'b1;
    nib    = c[3:0];
    if (c >= CH_A_LO && c <= CH_F_LO) begin
      nib = 4'(c - CH_A_LO) + 4'd10;
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      nib = 4'(c - CH_A_UP) + 4'd10;
    end else if (!(c >= CH_ZERO && c <= CH_NINE)) begin
      is_hex = 1'b0;
    end
    if (c == CH_NUL) begin
      case (mode)
        MODE_DEC: ok = 1'b1;
        MODE_HEX: ok = (digits > HEX_START);
        default:  ok = verdict;
      endcase
      res.ok    = ok;
      res.value = ok ? acc : 32'd0;
      expected_q.push_back(res);
      clear_parser();
    end else if (mode == MODE_DEC) begin
      if (digits == 4'd1 && lead_zero && (c == CH_X_LO || c == CH_X_UP)) begin
        mode   = MODE_HEX;
        digits = HEX_START;
        acc    = '0;
      end else if ((c == CH_K_LO || c == CH_K_UP) && digits != 4'd0) begin
        acc = acc << 10;
        settle(1'b1);
      end else if ((c == CH_M_LO || c == CH_M_UP) && digits != 4'd0) begin
        acc = acc << 20;
        settle(1'b1);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        acc = acc * 32'd10 + 32'(c[3:0]);
        if (digits == 4'd0) begin
          lead_zero = (c == CH_ZERO);
        end
        digits = digits + 4'd1;
        if (digits >= DIGIT_LIMIT) begin
          settle(1'b0);
        end
      end else begin
        settle(1'b0);
      end
    end else if (mode == MODE_HEX) begin
      if (is_hex) begin
        acc    = {acc[27:0], nib};
        digits = digits + 4'd1;
        if (digits >= DIGIT_LIMIT) begin
          settle(1'b0);
        end
      end else begin
        settle(1'b0);
      end
    end
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    if (fail_count < 100) begin
      $display("%0t ns: mismatch on %s, got %h, want %h", $time, field, got, want);
    end
    fail_count++;
  endtask

  task automatic check_result();
    parse_res_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result", out_mon.value, 32'd0);
    end else begin
      want = expected_q.pop_front();
      if (out_mon.valid_res !== want.ok) begin
        report("valid_res", 32'(out_mon.valid_res), 32'(want.ok));
      end
      if (out_mon.value !== want.value) begin
        report("value", out_mon.value, want.value);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_q.delete();
      results_seen <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result();
        results_seen <= results_seen + 1;
      end
      if (in_mon.valid && in_mon.ready) begin
        advance_parser(in_mon.char_code);
      end
    end
  end

endmodule

// File: tb/tb_number_text_parser.sv
// ----------------------------------------------------------------------------
// Number text parser testbench
// Feeds directed and random strings (decimal, hex, suffixed, broken and noise)
// with random idling on both channels, one long result stall and two full
// drains, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_number_text_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import ntp_pkg::*;

  typedef logic [7:0] chars_t[$];

  localparam int unsigned TEXT_ITEMS  = 1950;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam logic [7:0]  SUFFIXES [4] = '{CH_K_LO, CH_K_UP, CH_M_LO, CH_M_UP};

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned nuls_sent   = 0;
  int unsigned chars_sent  = 0;
  int unsigned holds_asked = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct     = 10;
  bit          calm        = 1'b0;

  string directed_texts[$] = '{"", "0", "0x", "0X", "0x0", "0X1f", "0xFFFFFFFF", "0xabcdef01",
                               "0x123456789", "4294967295", "4294967296", "12345678901",
                               "k", "M", "7k", "3K", "5m", "4095M", "0m", "1kz9", "0xk",
                               "00x1", "12a"};

  ntp_char_if in_ch();
  ntp_res_if  out_ch();

  number_text_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ntp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_number_text_parser failed");
      $finish;
    end
  end

  function automatic chars_t as_chars(input string s);
    chars_t q;
    for (int i = 0; i < s.len(); i++) begin
      q.push_back(s[i]);
    end
    return q;
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) begin
      return CH_ZERO + 8'(v);
    end
    return ($urandom_range(1) ? CH_A_UP : CH_A_LO) + 8'(v - 10);
  endfunction

  function automatic chars_t random_text();
    chars_t      q;
    int unsigned kind;
    int unsigned n;
    int unsigned s;
    kind = $urandom_range(99);
    if (kind < 35) begin
      n = ($urandom_range(3) == 0) ? 10 : $urandom_range(1, 10);
      repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(9)));
      s = $urandom_range(7);
      if (s < 4) begin
        q.push_back(SUFFIXES[s]);
        if ($urandom_range(2) == 0) begin
          repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(1, 255)));
        end
      end
    end else if (kind < 65) begin
      q.push_back(CH_ZERO);
      q.push_back($urandom_range(1) ? CH_X_UP : CH_X_LO);
      n = ($urandom_range(3) == 0) ? 8 : $urandom_range(1, 8);
      repeat (n) q.push_back(hex_char($urandom_range(15)));
    end else if (kind < 80) begin
      case ($urandom_range(7))
        0: ;
        1: begin
          q.push_back(CH_ZERO);
          q.push_back($urandom_range(1) ? CH_X_UP : CH_X_LO);
        end
        2: repeat ($urandom_range(11, 13)) q.push_back(CH_ZERO + 8'($urandom_range(9)));
        3: begin
          q.push_back(CH_ZERO);
          q.push_back(CH_X_LO);
          repeat ($urandom_range(9, 10)) q.push_back(hex_char($urandom_range(15)));
        end
        4: begin
          q.push_back(SUFFIXES[$urandom_range(3)]);
          repeat ($urandom_range(0, 3)) q.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
        5: begin
          q.push_back(CH_ZERO);
          q.push_back(CH_X_UP);
          repeat ($urandom_range(0, 4)) q.push_back(hex_char($urandom_range(15)));
          q.push_back(SUFFIXES[$urandom_range(3)]);
          repeat ($urandom_range(0, 2)) q.push_back(hex_char($urandom_range(15)));
        end
        6: begin
          repeat ($urandom_range(1, 9)) q.push_back(CH_ZERO + 8'($urandom_range(9)));
          q.insert($urandom_range(q.size()), 8'($urandom_range(1, 255)));
        end
        default: q.push_back(CH_ZERO);
      endcase
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(1)) begin
          q.push_back(8'($urandom_range(1, 255)));
        end else begin
          q.push_back(8'($urandom_range(8'h30, 8'h7a)));
        end
      end
    end
    return q;
  endfunction

  task automatic put_char(input logic [7:0] c);
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (c == CH_NUL) begin
      nuls_sent++;
    end
    chars_sent++;
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.char_code <= 8'($urandom);
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_text(input chars_t q);
    foreach (q[i]) begin
      put_char(q[i]);
    end
    put_char(CH_NUL);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_seen != nuls_sent) @(posedge clk);
  endtask

  initial begin
    int unsigned held_gap;
    int unsigned text_count;
    bit          pressed;
    bit          paused;
    pressed         = 1'b0;
    paused          = 1'b0;
    text_count      = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= CH_NUL;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_texts[i]) begin
      send_text(as_chars(directed_texts[i]));
    end
    send_text('{8'h80});
    send_text('{8'hff});
    send_text('{8'h31, 8'hc3, 8'h32});

    while (chars_sent < TEXT_ITEMS) begin
      if (text_count % 15 == 0) begin
        case ($urandom_range(3))
          0, 1: gap_pct = 0;
          2:    gap_pct = 10;
          default: gap_pct = 30;
        endcase
      end
      text_count++;
      if (!pressed && chars_sent > TEXT_ITEMS / 3) begin
        pressed     = 1'b1;
        holds_asked <= holds_asked + 1;
        held_gap    = gap_pct;
        gap_pct     = 0;
        repeat (40) send_text(as_chars("7"));
        gap_pct = held_gap;
      end
      if (!paused && chars_sent > TEXT_ITEMS * 2 / 3) begin
        paused = 1'b1;
        wait_drained();
      end
      if (chars_sent > TEXT_ITEMS * 17 / 20) begin
        calm <= 1'b1;
      end
      send_text(random_text());
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_number_text_parser passed");
    end else begin
      $display("tb_number_text_parser failed");
    end
    $finish;
  end

  initial begin
    int unsigned holds_done;
    int unsigned stall_pct;
    int unsigned left;
    holds_done   = 0;
    stall_pct    = 0;
    left         = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (left == 0) begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 5;
          2: stall_pct = 20;
          default: stall_pct = 50;
        endcase
        left = $urandom_range(50, 200);
      end
      left--;
      if (holds_asked != holds_done) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

endmodule
